### sv/cts_pkg.sv
// Shared types and constants for the calendar time-setting editor.
// No dependencies; imported by every module of the block.
package cts_pkg;

	// Command codes carried in the input word
	typedef enum logic [2:0] {
		CMD_LOAD  = 3'd0,
		CMD_MODE  = 3'd1,
		CMD_NEXT  = 3'd2,
		CMD_UP    = 3'd3,
		CMD_DOWN  = 3'd4,
		CMD_TICK  = 3'd5
	} cmd_t;

	// Field selection codes
	localparam logic [2:0] FLD_YEAR   = 3'd0;
	localparam logic [2:0] FLD_MONTH  = 3'd1;
	localparam logic [2:0] FLD_DAY    = 3'd2;
	localparam logic [2:0] FLD_HOUR   = 3'd3;
	localparam logic [2:0] FLD_MINUTE = 3'd4;
	localparam logic [2:0] FLD_SECOND = 3'd5;

	localparam int unsigned BLINK_W = 10;
	localparam logic [BLINK_W-1:0] BLINK_RESET = 10'd500;

	// Input word
	typedef struct packed {
		cmd_t       command;
		logic [6:0] rtc_year;
		logic [3:0] rtc_month;
		logic [4:0] rtc_day;
		logic [4:0] rtc_hour;
		logic [5:0] rtc_minute;
		logic [5:0] rtc_second;
	} item_t;

	// Result word
	typedef struct packed {
		logic [6:0] out_year;
		logic [3:0] out_month;
		logic [4:0] out_day;
		logic [4:0] out_hour;
		logic [5:0] out_minute;
		logic [5:0] out_second;
		logic [2:0] selected_field;
		logic       editing;
		logic       blank_selected;
		logic       write_back;
	} result_t;

	// Calendar time held by the editor
	typedef struct packed {
		logic [6:0] year;
		logic [3:0] month;
		logic [4:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} cal_time_t;

endpackage

### sv/cts_in_reg.sv
// Input register stage of the calendar time-setting editor.
// Depends on cts_pkg for the input word type.
module cts_in_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  cts_pkg::item_t in_item,
	input  logic           take,
	output logic           valid_s1,
	output cts_pkg::item_t item_s1
);
	import cts_pkg::*;

	// Stage is free when empty or when its word moves on this cycle
	assign in_ready = !valid_s1 || take;

	// Valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

### sv/cts_core.sv
// Editor state and single-pass update logic of the calendar time-setting editor.
// Depends on cts_pkg for command codes, field codes and word types.
module cts_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [cts_pkg::BLINK_W-1:0]  cfg_data,
	input  logic                         fire,
	input  cts_pkg::item_t               item_s1,
	output cts_pkg::result_t             result
);
	import cts_pkg::*;

	// Days in the month; leap year every fourth year
	function automatic logic [4:0] month_len(input logic [6:0] y, input logic [3:0] m);
		logic [4:0] len;
		len = 5'd31;
		if (m == 4'd2) begin
			len = (y[1:0] == 2'b00) ? 5'd29 : 5'd28;
		end else if (m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11) begin
			len = 5'd30;
		end
		return len;
	endfunction

	// Bring every field back into range after an edit
	function automatic cal_time_t normalize(input cal_time_t t);
		cal_time_t  r;
		logic [4:0] len;
		r = t;
		if (r.year > 7'd99) r.year = '0;
		if (r.month > 4'd12) r.month = 4'd1;
		if (r.month == 4'd0) r.month = 4'd12;
		len = month_len(r.year, r.month);
		if (r.day == 5'd0) r.day = len;
		if (r.day > len) r.day = 5'd1;
		if (r.hour > 5'd23) r.hour = '0;
		if (r.minute > 6'd59) r.minute = '0;
		if (r.second > 6'd59) r.second = '0;
		return r;
	endfunction

	// Increment the selected field, wrapping at the field width
	function automatic cal_time_t field_up(input cal_time_t t, input logic [2:0] sel);
		cal_time_t r;
		r = t;
		unique case (sel)
			FLD_YEAR:   r.year   = t.year + 7'd1;
			FLD_MONTH:  r.month  = t.month + 4'd1;
			FLD_DAY:    r.day    = t.day + 5'd1;
			FLD_HOUR:   r.hour   = t.hour + 5'd1;
			FLD_MINUTE: r.minute = t.minute + 6'd1;
			default:    r.second = t.second + 6'd1;
		endcase
		return r;
	endfunction

	// Decrement the selected field with wrap-around; a day of zero stays zero here
	function automatic cal_time_t field_down(input cal_time_t t, input logic [2:0] sel);
		cal_time_t r;
		r = t;
		unique case (sel)
			FLD_YEAR:   r.year   = (t.year == 7'd0) ? 7'd99 : t.year - 7'd1;
			FLD_MONTH:  r.month  = (t.month <= 4'd1) ? 4'd12 : t.month - 4'd1;
			FLD_DAY:    r.day    = (t.day == 5'd0) ? 5'd0 : t.day - 5'd1;
			FLD_HOUR:   r.hour   = (t.hour == 5'd0) ? 5'd23 : t.hour - 5'd1;
			FLD_MINUTE: r.minute = (t.minute == 6'd0) ? 6'd59 : t.minute - 6'd1;
			default:    r.second = (t.second == 6'd0) ? 6'd59 : t.second - 6'd1;
		endcase
		return r;
	endfunction

	cal_time_t          time_q, time_n;
	logic [2:0]         sel_q, sel_n;
	logic               edit_q, edit_n;
	logic               blink_q, blink_n;
	logic [BLINK_W-1:0] tick_q, tick_n, tick_inc;
	logic [BLINK_W-1:0] period_q;
	logic               wb;

	assign cfg_ready = 1'b1;

	// Blink period register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= BLINK_RESET;
		end else if (cfg_valid) begin
			period_q <= cfg_data;
		end
	end

	// Next state for the word in the input stage
	always_comb begin
		time_n   = time_q;
		sel_n    = sel_q;
		edit_n   = edit_q;
		blink_n  = blink_q;
		tick_n   = tick_q;
		wb       = 1'b0;
		tick_inc = tick_q + 1'b1;
		unique case (item_s1.command)
			CMD_LOAD: begin
				if (!edit_q) begin
					time_n = '{year: item_s1.rtc_year, month: item_s1.rtc_month,
						day: item_s1.rtc_day, hour: item_s1.rtc_hour,
						minute: item_s1.rtc_minute, second: item_s1.rtc_second};
				end
			end
			CMD_MODE: begin
				if (!edit_q) begin
					edit_n = 1'b1;
					sel_n  = FLD_YEAR;
				end else begin
					edit_n = 1'b0;
					wb     = 1'b1;
				end
			end
			CMD_NEXT: begin
				if (edit_q) begin
					sel_n = (sel_q >= FLD_SECOND) ? FLD_YEAR : sel_q + 3'd1;
				end
			end
			CMD_UP: begin
				if (edit_q) time_n = normalize(field_up(time_q, sel_q));
			end
			CMD_DOWN: begin
				if (edit_q) time_n = normalize(field_down(time_q, sel_q));
			end
			CMD_TICK: begin
				if (tick_inc >= period_q) begin
					tick_n  = '0;
					blink_n = !blink_q;
				end else begin
					tick_n = tick_inc;
				end
			end
			default: ;
		endcase
	end

	// Editor state, updated once per word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q  <= '{year: 7'd0, month: 4'd1, day: 5'd1, hour: 5'd0,
				minute: 6'd0, second: 6'd0};
			sel_q   <= FLD_YEAR;
			edit_q  <= 1'b0;
			blink_q <= 1'b0;
			tick_q  <= '0;
		end else if (fire) begin
			time_q  <= time_n;
			sel_q   <= sel_n;
			edit_q  <= edit_n;
			blink_q <= blink_n;
			tick_q  <= tick_n;
		end
	end

	// Result word reflects the state after this step
	assign result = '{out_year: time_n.year, out_month: time_n.month, out_day: time_n.day,
		out_hour: time_n.hour, out_minute: time_n.minute, out_second: time_n.second,
		selected_field: sel_n, editing: edit_n, blank_selected: edit_n & blink_n,
		write_back: wb};

endmodule

### sv/cts_out_reg.sv
// Result register stage of the calendar time-setting editor.
// Depends on cts_pkg for the result word type.
module cts_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  cts_pkg::result_t result,
	output logic             take,
	output logic             out_valid,
	input  logic             out_ready,
	output cts_pkg::result_t out_result
);
	import cts_pkg::*;

	logic    valid_s2;
	result_t result_s2;

	// Free when empty or when the held word leaves this cycle
	assign take       = !valid_s2 || out_ready;
	assign out_valid  = valid_s2;
	assign out_result = result_s2;

	// Valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (take) begin
			valid_s2 <= fire;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (fire) begin
			result_s2 <= result;
		end
	end

endmodule

### sv/calendar_time_set_editor.sv
// Top level of the calendar time-setting editor.
// Depends on cts_pkg, cts_in_reg, cts_core and cts_out_reg.
//
// Usage:
//   Input channel (in_valid/in_ready/in_item) carries one command word: load,
//   mode toggle, next field, up, down or tick, plus the clock chip reading.
//   Output channel (out_valid/out_ready/out_result) returns one result word
//   per command: the time fields, selected field, edit flag, blank flag and
//   a write_back pulse on the word that leaves edit mode.
//   Config channel (cfg_valid/cfg_ready/cfg_data) writes the blink period;
//   cfg_ready is always high. Write it only while the block is idle.
// Timing:
//   A word is registered in the input register, is evaluated in a single
//   pass against the editor state and lands in the result register. One word
//   per cycle sustained while out_ready stays high.
// Reset:
//   arst_n clears both stages and sets the time to year 0, January 1,
//   00:00:00, not editing, blink period 500.
// Stall:
//   While out_ready is low the result word holds; the input register still
//   takes one more word, then in_ready drops until the output drains.
module calendar_time_set_editor (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  cts_pkg::item_t               in_item,
	output logic                         out_valid,
	input  logic                         out_ready,
	output cts_pkg::result_t             out_result,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [cts_pkg::BLINK_W-1:0]  cfg_data
);
	import cts_pkg::*;

	logic    take;
	logic    valid_s1;
	item_t   item_s1;
	logic    fire;
	result_t result;

	// Word in the input stage is evaluated when the result register is free
	assign fire = valid_s1 && take;

	cts_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	cts_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.fire      (fire),
		.item_s1   (item_s1),
		.result    (result)
	);

	cts_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.result     (result),
		.take       (take),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_result (out_result)
	);

`ifndef ASSERT_OFF
	// Leaving edit mode cannot report editing at the same time
	a_wb_not_editing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_result.write_back |-> !out_result.editing)
		else $error("write_back with editing set");

	// Blanking only happens in edit mode
	a_blank_editing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_result.blank_selected |-> out_result.editing)
		else $error("blank_selected outside edit mode");

	// Empty output stage never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// An evaluated word shows up at the output next cycle
	a_fire_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid)
		else $error("evaluated word lost");
`endif

endmodule

### tb/calendar_time_set_editor_tb.sv
// Self-checking testbench for calendar_time_set_editor: key words in, display words out.
// Keeps its own model of the editor state to predict each result word.
// Depends on cts_pkg and the calendar_time_set_editor RTL.
module calendar_time_set_editor_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cts_pkg::*;

	// command codes outside the defined set; the editor ignores them
	localparam logic [2:0] CMD_SPARE_6 = 3'd6;
	localparam logic [2:0] CMD_SPARE_7 = 3'd7;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_KEYS = 300;
	localparam int MAX_PRINTED = 100;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	result_t out_result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [BLINK_W-1:0] cfg_data = '0;

	calendar_time_set_editor u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_result (out_result),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always #6 clk = ~clk;

	// predicted editor state
	cal_time_t ed_time = '{year: 7'd0, month: 4'd1, day: 5'd1, hour: 5'd0,
		minute: 6'd0, second: 6'd0};
	logic [2:0] ed_sel = FLD_YEAR;
	logic ed_editing = 1'b0;
	logic ed_blink = 1'b0;
	logic [BLINK_W-1:0] ed_ticks = '0;
	logic [BLINK_W-1:0] ed_period = BLINK_RESET;

	item_t key_q[$];
	result_t readout_q[$];
	int key_count = 0;
	logic gen_editing = 1'b0;
	int mismatches = 0;
	int words_seen = 0;

	function automatic int unsigned month_days(int unsigned yr, int unsigned mo);
		if (mo == 2) return (yr % 4 == 0) ? 29 : 28;
		if (mo == 4 || mo == 6 || mo == 9 || mo == 11) return 30;
		return 31;
	endfunction

	// apply one key word to the predicted state and return the display word
	function automatic result_t step_editor(item_t w);
		int unsigned yr, mo, dy, hr, mi, se, len;
		logic wb;
		result_t r;
		yr = 32'(ed_time.year);
		mo = 32'(ed_time.month);
		dy = 32'(ed_time.day);
		hr = 32'(ed_time.hour);
		mi = 32'(ed_time.minute);
		se = 32'(ed_time.second);
		wb = 1'b0;
		case (w.command)
			CMD_LOAD: begin
				if (!ed_editing) begin
					yr = 32'(w.rtc_year);
					mo = 32'(w.rtc_month);
					dy = 32'(w.rtc_day);
					hr = 32'(w.rtc_hour);
					mi = 32'(w.rtc_minute);
					se = 32'(w.rtc_second);
				end
			end
			CMD_MODE: begin
				if (!ed_editing) begin
					ed_editing = 1'b1;
					ed_sel = FLD_YEAR;
				end else begin
					ed_editing = 1'b0;
					wb = 1'b1;
				end
			end
			CMD_NEXT: begin
				if (ed_editing) ed_sel = (ed_sel >= FLD_SECOND) ? FLD_YEAR : ed_sel + 3'd1;
			end
			CMD_UP, CMD_DOWN: begin
				if (ed_editing) begin
					if (w.command == CMD_UP) begin
						case (ed_sel)
							FLD_YEAR:   yr = (yr + 1) % 128;
							FLD_MONTH:  mo = (mo + 1) % 16;
							FLD_DAY:    dy = (dy + 1) % 32;
							FLD_HOUR:   hr = (hr + 1) % 32;
							FLD_MINUTE: mi = (mi + 1) % 64;
							default:    se = (se + 1) % 64;
						endcase
					end else begin
						case (ed_sel)
							FLD_YEAR:   yr = (yr == 0) ? 99 : yr - 1;
							FLD_MONTH:  mo = (mo <= 1) ? 12 : mo - 1;
							FLD_DAY:    dy = (dy == 0) ? 0 : dy - 1;
							FLD_HOUR:   hr = (hr == 0) ? 23 : hr - 1;
							FLD_MINUTE: mi = (mi == 0) ? 59 : mi - 1;
							default:    se = (se == 0) ? 59 : se - 1;
						endcase
					end
					// pull every field back into range, day against month length
					if (yr > 99) yr = 0;
					if (mo > 12) mo = 1;
					if (mo < 1) mo = 12;
					len = month_days(yr, mo);
					if (dy < 1) dy = len;
					if (dy > len) dy = 1;
					if (hr > 23) hr = 0;
					if (mi > 59) mi = 0;
					if (se > 59) se = 0;
				end
			end
			CMD_TICK: begin
				ed_ticks = ed_ticks + 1'b1;
				if (ed_ticks >= ed_period) begin
					ed_ticks = '0;
					ed_blink = ~ed_blink;
				end
			end
			default: ;
		endcase
		ed_time.year = yr[6:0];
		ed_time.month = mo[3:0];
		ed_time.day = dy[4:0];
		ed_time.hour = hr[4:0];
		ed_time.minute = mi[5:0];
		ed_time.second = se[5:0];
		r.out_year = ed_time.year;
		r.out_month = ed_time.month;
		r.out_day = ed_time.day;
		r.out_hour = ed_time.hour;
		r.out_minute = ed_time.minute;
		r.out_second = ed_time.second;
		r.selected_field = ed_sel;
		r.editing = ed_editing;
		r.blank_selected = ed_editing & ed_blink;
		r.write_back = wb;
		return r;
	endfunction

	// key word with the given command and a random clock chip reading
	function automatic item_t random_key(cmd_t c);
		item_t w;
		w.command = c;
		w.rtc_year = 7'($urandom_range(0, 127));
		w.rtc_month = 4'($urandom_range(0, 15));
		w.rtc_day = 5'($urandom_range(0, 31));
		w.rtc_hour = 5'($urandom_range(0, 31));
		w.rtc_minute = 6'($urandom_range(0, 63));
		w.rtc_second = 6'($urandom_range(0, 63));
		return w;
	endfunction

	// load word, mostly a plausible reading, late February days favored
	function automatic item_t reading_key();
		item_t w;
		w = random_key(CMD_LOAD);
		if ($urandom_range(0, 6) != 0) begin
			w.rtc_year = 7'($urandom_range(0, 99));
			w.rtc_month = 4'($urandom_range(1, 12));
			w.rtc_day = 5'($urandom_range(1, 31));
			w.rtc_hour = 5'($urandom_range(0, 23));
			w.rtc_minute = 6'($urandom_range(0, 59));
			w.rtc_second = 6'($urandom_range(0, 59));
			if ($urandom_range(0, 4) == 0) begin
				w.rtc_month = 4'd2;
				w.rtc_day = 5'($urandom_range(27, 29));
			end
		end
		return w;
	endfunction

	function automatic item_t load_key(int yr, int mo, int dy, int hr, int mi, int se);
		item_t w;
		w.command = CMD_LOAD;
		w.rtc_year = 7'(yr);
		w.rtc_month = 4'(mo);
		w.rtc_day = 5'(dy);
		w.rtc_hour = 5'(hr);
		w.rtc_minute = 6'(mi);
		w.rtc_second = 6'(se);
		return w;
	endfunction

	task automatic push_key(item_t w);
		if (w.command == CMD_MODE) gen_editing = ~gen_editing;
		key_q.push_back(w);
		key_count++;
	endtask

	// one edit session: optional load, enter, edits and ticks, usually leave
	task automatic queue_session();
		int n;
		if (!gen_editing) begin
			if ($urandom_range(0, 3) != 0) push_key(reading_key());
			push_key(random_key(CMD_MODE));
		end
		n = $urandom_range(4, 40);
		repeat (n) begin
			case ($urandom_range(0, 9))
				0, 1:    push_key(random_key(CMD_NEXT));
				2, 3, 4: push_key(random_key(CMD_UP));
				5, 6, 7: push_key(random_key(CMD_DOWN));
				default: push_key(random_key(CMD_TICK));
			endcase
		end
		if ($urandom_range(0, 5) != 0) push_key(random_key(CMD_MODE));
	endtask

	task automatic queue_random(int n);
		int start;
		start = key_count;
		while (key_count - start < n) begin
			if ($urandom_range(0, 9) == 0)
				push_key(random_key(cmd_t'($urandom_range(0, 7))));
			else
				queue_session();
		end
	endtask

	task automatic wait_idle();
		while (key_q.size() != 0 || in_valid || readout_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_blink_period(logic [BLINK_W-1:0] period);
		@(posedge clk);
		cfg_data <= period;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		ed_period = period;
	endtask

	task automatic report_mismatch(string msg);
		// print the first ones only, keep counting
		if (mismatches < MAX_PRINTED) $display("MISMATCH at %0t, word %0d: %s", $time, words_seen, msg);
		mismatches++;
	endtask

	task automatic check_field(string name, int unsigned got, int unsigned want);
		if (got != want) report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
	endtask

	// key driver: bursts of random length separated by random gaps
	int burst_left = 1;
	int gap_left = 0;
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) readout_q.push_back(step_editor(in_item));
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (key_q.size() != 0) begin
					in_item <= key_q.pop_front();
					in_valid <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
							: $urandom_range(1, 20);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// display monitor: ready follows a duty pattern that changes every so often
	int rx_cycle = 0;
	int rx_span = 100;
	int rx_period = 1;
	int rx_hold = 0;
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (readout_q.size() == 0) begin
					report_mismatch("display word with nothing expected");
				end else begin
					want = readout_q.pop_front();
					check_field("out_year", 32'(out_result.out_year), 32'(want.out_year));
					check_field("out_month", 32'(out_result.out_month), 32'(want.out_month));
					check_field("out_day", 32'(out_result.out_day), 32'(want.out_day));
					check_field("out_hour", 32'(out_result.out_hour), 32'(want.out_hour));
					check_field("out_minute", 32'(out_result.out_minute),
						32'(want.out_minute));
					check_field("out_second", 32'(out_result.out_second),
						32'(want.out_second));
					check_field("selected_field", 32'(out_result.selected_field),
						32'(want.selected_field));
					check_field("editing", 32'(out_result.editing), 32'(want.editing));
					check_field("blank_selected", 32'(out_result.blank_selected),
						32'(want.blank_selected));
					check_field("write_back", 32'(out_result.write_back),
						32'(want.write_back));
				end
				words_seen++;
			end
			rx_cycle++;
			if (rx_cycle >= rx_span) begin
				rx_cycle = 0;
				rx_span = $urandom_range(64, 256);
				rx_period = $urandom_range(1, 8);
				rx_hold = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, rx_period - 1);
			end
			out_ready <= (rx_cycle % rx_period) >= rx_hold;
		end
	end

	// stimulus: directed edits, then random sessions under several blink periods
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// no effect on the display word outside edit mode
		push_key(random_key(CMD_TICK));
		push_key(random_key(CMD_NEXT));
		push_key(random_key(CMD_UP));
		push_key(random_key(cmd_t'(CMD_SPARE_6)));
		// every field at its top, then wrap each up and back down
		push_key(load_key(99, 12, 31, 23, 59, 59));
		push_key(random_key(CMD_MODE));
		push_key(load_key(0, 1, 1, 0, 0, 0));
		for (int f = 0; f < 6; f++) begin
			push_key(random_key(CMD_UP));
			push_key(random_key(CMD_DOWN));
			push_key(random_key(CMD_NEXT));
		end
		push_key(random_key(cmd_t'(CMD_SPARE_7)));
		push_key(random_key(CMD_MODE));
		// all-ones reading taken as is, then normalized by an edit
		push_key(load_key(127, 15, 31, 31, 63, 63));
		push_key(random_key(CMD_MODE));
		push_key(random_key(CMD_UP));
		push_key(random_key(CMD_MODE));
		wait_idle();

		queue_random(PHASE_KEYS);
		wait_idle();
		write_blink_period(10'd1);
		queue_random(PHASE_KEYS);
		wait_idle();
		write_blink_period(10'd0);
		queue_random(PHASE_KEYS);
		wait_idle();
		write_blink_period(10'd1023);
		queue_random(PHASE_KEYS);
		wait_idle();
		write_blink_period(BLINK_W'($urandom_range(2, 9)));
		queue_random(PHASE_KEYS);
		wait_idle();
		write_blink_period(BLINK_W'($urandom_range(1, 1023)));
		queue_random(PHASE_KEYS);
		wait_idle();

		if (mismatches == 0) begin
			$display("** calendar_time_set_editor: PASSED **");
		end else begin
			$display("** calendar_time_set_editor: FAILED **");
		end
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("timeout with %0d display words still expected", readout_q.size());
		$display("** calendar_time_set_editor: FAILED **");
		$finish;
	end

endmodule

### calendar_time_set_editor.f
sv/cts_pkg.sv
sv/cts_in_reg.sv
sv/cts_core.sv
sv/cts_out_reg.sv
sv/calendar_time_set_editor.sv
tb/calendar_time_set_editor_tb.sv
